@@ rtl/rau_pkg.sv @@
package rau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int DW = 2 * DATA_WIDTH;
  localparam int KW = $clog2(DW);

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_EQ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_ZDEN = 2'd1,
    STS_OVF  = 2'd2
  } status_t;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/rational_arithmetic_unit_top.sv @@
// Result timing is data dependent; a zero denominator is reported in the
//   cycle after accept.
// Throughput: one beat at a time; in_ready is low from accept until the
//   result beat is taken. Time is set by the bit-serial binary gcd and the
//   one-bit-per-cycle divider, run up to four reductions per beat.
// Reset: rst_n synchronous, active low; returns to idle, no result pending.
module rational_arithmetic_unit_top import rau_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_operation,
  input  logic signed [DATA_WIDTH-1:0] in_a_num,
  input  logic signed [DATA_WIDTH-1:0] in_a_den,
  input  logic signed [DATA_WIDTH-1:0] in_b_num,
  input  logic signed [DATA_WIDTH-1:0] in_b_den,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_res_num,
  output logic [DATA_WIDTH-2:0]        out_res_den,
  output logic                         out_is_equal,
  output logic [1:0]                   out_status
);

  localparam int W = DATA_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_GCD, S_GWAIT, S_DIVX, S_DXWAIT, S_DIVY, S_DYWAIT, S_POST,
    S_MUL1, S_MUL2, S_MUL3, S_COMB, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_A, PH_B, PH_DEN, PH_RES} phase_t;

  state_t        state_r, state_nxt;
  phase_t        ph_r, ph_nxt;
  op_t           op_r, op_nxt;
  logic          sa_r, sa_nxt, sb_r, sb_nxt;
  logic [W-1:0]  bn_mag_r, bn_mag_nxt, bd_mag_r, bd_mag_nxt;
  logic [DW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [W-1:0]  a_n_r, a_n_nxt, a_d_r, a_d_nxt, b_n_r, b_n_nxt, b_d_r, b_d_nxt;
  logic [W-1:0]  adg_r, adg_nxt, bdg_r, bdg_nxt;
  logic          a_neg_r, a_neg_nxt, b_neg_r, b_neg_nxt, r_neg_r, r_neg_nxt;
  logic [W-1:0]  res_num_r, res_num_nxt;
  logic [W-2:0]  res_den_r, res_den_nxt;
  logic          is_eq_r, is_eq_nxt;
  status_t       status_r, status_nxt;

  logic          gcd_start, gcd_done, div_start, div_done;
  logic [DW-1:0] gcd_g, div_q, div_n;
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] mul_p;
  logic          addsub, in_zd, bneg, neg_f, ovf, xnz;
  logic [W-1:0]  xl;
  op_t           in_op;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (x_r),
    .b_in  (y_r),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n_in  (div_n),
    .d_in  (gcd_g),
    .done  (div_done),
    .q     (div_q)
  );

  assign gcd_start = (state_r == S_GCD);
  assign div_start = (state_r == S_DIVX) || (state_r == S_DIVY);
  assign div_n     = (state_r == S_DIVX) ? x_r : y_r;
  assign addsub    = (op_r == OP_ADD) || (op_r == OP_SUB);
  assign mul_p     = DW'(mul_a) * DW'(mul_b);

  assign in_op = (in_operation > 3'(OP_EQ)) ? OP_NORM : op_t'(in_operation);
  assign in_zd = (in_a_den == '0) || ((in_op != OP_NORM) && (in_b_den == '0)) ||
                 ((in_op == OP_DIV) && (in_b_num == '0));

  assign bneg  = (op_r == OP_SUB) ? ((b_n_r != '0) && !b_neg_r) : b_neg_r;
  assign xl    = x_r[W-1:0];
  assign xnz   = (x_r != '0);
  assign neg_f = r_neg_r && xnz;
  assign ovf   = (x_r[DW-1:W] != '0) || (y_r[DW-1:W-1] != '0) ||
                 (xl[W-1] && !(neg_f && (xl[W-2:0] == '0)));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL1: begin
        mul_a = a_n_r;
        mul_b = addsub ? bdg_r : ((op_r == OP_MUL) ? b_n_r : b_d_r);
      end
      S_MUL2: begin
        mul_a = addsub ? b_n_r : a_d_r;
        mul_b = addsub ? adg_r : ((op_r == OP_MUL) ? b_d_r : b_n_r);
      end
      S_MUL3: begin
        mul_a = a_d_r;
        mul_b = bdg_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    op_nxt      = op_r;
    sa_nxt      = sa_r;
    sb_nxt      = sb_r;
    bn_mag_nxt  = bn_mag_r;
    bd_mag_nxt  = bd_mag_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    a_n_nxt     = a_n_r;
    a_d_nxt     = a_d_r;
    b_n_nxt     = b_n_r;
    b_d_nxt     = b_d_r;
    adg_nxt     = adg_r;
    bdg_nxt     = bdg_r;
    a_neg_nxt   = a_neg_r;
    b_neg_nxt   = b_neg_r;
    r_neg_nxt   = r_neg_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;
    is_eq_nxt   = is_eq_r;
    status_nxt  = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_op;
          sa_nxt      = in_a_num[W-1] ^ in_a_den[W-1];
          sb_nxt      = in_b_num[W-1] ^ in_b_den[W-1];
          bn_mag_nxt  = mag(in_b_num);
          bd_mag_nxt  = mag(in_b_den);
          x_nxt       = DW'(mag(in_a_num));
          y_nxt       = DW'(mag(in_a_den));
          ph_nxt      = PH_A;
          res_num_nxt = '0;
          res_den_nxt = '0;
          is_eq_nxt   = 1'b0;
          status_nxt  = STS_OK;
          if (in_zd) begin
            status_nxt = STS_ZDEN;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD:    state_nxt = S_GWAIT;
      S_GWAIT:  if (gcd_done) state_nxt = S_DIVX;
      S_DIVX:   state_nxt = S_DXWAIT;
      S_DXWAIT: begin
        if (div_done) begin
          x_nxt     = div_q;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY:   state_nxt = S_DYWAIT;
      S_DYWAIT: begin
        if (div_done) begin
          y_nxt     = div_q;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        unique case (ph_r)
          PH_A: begin
            a_n_nxt   = xl;
            a_d_nxt   = y_r[W-1:0];
            a_neg_nxt = xnz && sa_r;
            if (op_r == OP_NORM) begin
              r_neg_nxt = xnz && sa_r;
              state_nxt = S_FIN;
            end else begin
              x_nxt     = DW'(bn_mag_r);
              y_nxt     = DW'(bd_mag_r);
              ph_nxt    = PH_B;
              state_nxt = S_GCD;
            end
          end
          PH_B: begin
            b_n_nxt   = xl;
            b_d_nxt   = y_r[W-1:0];
            b_neg_nxt = xnz && sb_r;
            if (op_r == OP_EQ) begin
              is_eq_nxt = (a_neg_r == (xnz && sb_r)) && (a_n_r == xl) &&
                          (a_d_r == y_r[W-1:0]);
              state_nxt = S_OUT;
            end else if (addsub) begin
              x_nxt     = DW'(a_d_r);
              ph_nxt    = PH_DEN;
              state_nxt = S_GCD;
            end else begin
              state_nxt = S_MUL1;
            end
          end
          PH_DEN: begin
            adg_nxt   = xl;
            bdg_nxt   = y_r[W-1:0];
            state_nxt = S_MUL1;
          end
          PH_RES: state_nxt = S_FIN;
          default: state_nxt = S_FIN;
        endcase
      end
      S_MUL1: begin
        x_nxt     = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        y_nxt = mul_p;
        if (addsub) begin
          state_nxt = S_MUL3;
        end else begin
          r_neg_nxt = a_neg_r ^ b_neg_r;
          ph_nxt    = PH_RES;
          state_nxt = S_GCD;
        end
      end
      S_MUL3: begin
        z_nxt     = mul_p;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        y_nxt = z_r;
        if (a_neg_r == bneg) begin
          x_nxt     = x_r + y_r;
          r_neg_nxt = a_neg_r;
        end else if (x_r >= y_r) begin
          x_nxt     = x_r - y_r;
          r_neg_nxt = a_neg_r;
        end else begin
          x_nxt     = y_r - x_r;
          r_neg_nxt = bneg;
        end
        ph_nxt    = PH_RES;
        state_nxt = S_GCD;
      end
      S_FIN: begin
        if (ovf) begin
          status_nxt = STS_OVF;
        end else begin
          res_num_nxt = neg_f ? (~xl + 1'b1) : xl;
          res_den_nxt = y_r[W-2:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ph_r      <= ph_nxt;
    op_r      <= op_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    bn_mag_r  <= bn_mag_nxt;
    bd_mag_r  <= bd_mag_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    a_n_r     <= a_n_nxt;
    a_d_r     <= a_d_nxt;
    b_n_r     <= b_n_nxt;
    b_d_r     <= b_d_nxt;
    adg_r     <= adg_nxt;
    bdg_r     <= bdg_nxt;
    a_neg_r   <= a_neg_nxt;
    b_neg_r   <= b_neg_nxt;
    r_neg_r   <= r_neg_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    is_eq_r   <= is_eq_nxt;
    status_r  <= status_nxt;
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_is_equal = is_eq_r;
  assign out_status   = status_r;

endmodule

@@ rtl/rau_gcd.sv @@
module rau_gcd import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] a_in,
  input  logic [DW-1:0] b_in,
  output logic          done,
  output logic [DW-1:0] g
);

  typedef enum logic [1:0] {G_IDLE, G_EVEN, G_AODD, G_LOOP} gst_t;

  gst_t          st_r, st_nxt;
  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, g_r, g_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    done_nxt = 1'b0;
    unique case (st_r)
      G_IDLE: begin
        if (start) begin
          if (a_in == '0) begin
            g_nxt    = b_in;
            done_nxt = 1'b1;
          end else if (b_in == '0) begin
            g_nxt    = a_in;
            done_nxt = 1'b1;
          end else begin
            a_nxt  = a_in;
            b_nxt  = b_in;
            k_nxt  = '0;
            st_nxt = G_EVEN;
          end
        end
      end
      G_EVEN: begin
        if (a_r[0] | b_r[0]) begin
          st_nxt = G_AODD;
        end else begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end
      end
      G_AODD: begin
        if (a_r[0]) st_nxt = G_LOOP;
        else        a_nxt = a_r >> 1;
      end
      G_LOOP: begin
        if (b_r == '0) begin
          g_nxt    = a_r << k_r;
          done_nxt = 1'b1;
          st_nxt   = G_IDLE;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = b_r;
          b_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      default: st_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
    if (!rst_n) begin
      st_r   <= G_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

@@ rtl/rau_div.sv @@
module rau_div import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] n_in,
  input  logic [DW-1:0] d_in,
  output logic          done,
  output logic [DW-1:0] q
);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   rs, diff;
  logic          ge;

  assign rs   = {r_r, q_r[DW-1]};
  assign ge   = rs >= {1'b0, d_r};
  assign diff = rs - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      r_nxt   = ge ? diff[DW-1:0] : rs[DW-1:0];
      q_nxt   = {q_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      q_nxt    = n_in;
      r_nxt    = '0;
      d_nxt    = d_in;
      cnt_nxt  = KW'(DW - 1);
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

@@ rtl/rau_checker.sv @@
module rau_props import rau_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_res_num,
  input logic [DATA_WIDTH-2:0] out_res_den,
  input logic                  out_is_equal,
  input logic [1:0]            out_status
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result beat is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after accept");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |->
      (out_res_num == '0) && (out_res_den == '0) && !out_is_equal)
    else $error("error beat with nonzero payload");

  a_equal_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_equal |-> (out_status == STS_OK) && (out_res_den == '0))
    else $error("equal flag with bad payload");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) &&
      $stable(out_status))
    else $error("result beat dropped or changed while stalled");

endmodule

bind rational_arithmetic_unit_top rau_props u_rau_props (.*);
